// ===== design/ers_pkg.sv =====
// ---------------------------------------------------------------------------
// ers_pkg
// Shared types and constants for the elevator request scheduler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ers_pkg;

    localparam int FLOORS = 4;
    localparam int IDX_W  = (FLOORS > 1) ? $clog2(FLOORS) : 1;

    // operation codes
    localparam logic [1:0] OP_ADD         = 2'd0;
    localparam logic [1:0] OP_CLEAR_FLOOR = 2'd1;
    localparam logic [1:0] OP_CLEAR_ALL   = 2'd2;
    localparam logic [1:0] OP_QUERY       = 2'd3;

    // request kinds
    localparam logic [1:0] BTN_UP    = 2'd0;
    localparam logic [1:0] BTN_DOWN  = 2'd1;
    localparam logic [1:0] BTN_CABIN = 2'd2;

    // travel direction codes, two's complement
    localparam logic signed [1:0] DIR_STOP = 2'sb00;
    localparam logic signed [1:0] DIR_UP   = 2'sb01;
    localparam logic signed [1:0] DIR_DOWN = 2'sb11;

    typedef struct packed {
        logic [FLOORS-1:0] up;
        logic [FLOORS-1:0] down;
        logic [FLOORS-1:0] cabin;
    } req_vec_t;

    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] cur;
        logic signed [1:0] dir;
    } scan_cmd_t;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  target;
        logic signed [1:0] dir;
    } scan_res_t;

endpackage

// ===== design/elevator_request_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// elevator_request_scheduler_unit
// Per-floor request bookkeeping with a LOOK-style next-target search.
// ---------------------------------------------------------------------------
// the floor scan tests one floor per cycle, first for the preferred kinds, then
//   for any request (only any request when stopped); an undefined direction
//   code skips the scan
// in_ready is low while a scan runs or its result waits for the output register
// reset clears all request vectors and the output valid, no clearing pass
`timescale 1ns / 1ps

module elevator_request_scheduler_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        op,
    input  logic [1:0]        floor,
    input  logic [1:0]        button,
    input  logic [1:0]        current_floor,
    input  logic signed [1:0] direction,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        target_floor,
    output logic signed [1:0] next_direction
);

    ers_pkg::req_vec_t  reqs;
    ers_pkg::scan_cmd_t cmd;
    ers_pkg::scan_res_t res;
    logic               scan_idle;
    logic               in_fire;
    logic               take;

    logic              out_valid_reg;
    logic [1:0]        target_reg;
    logic signed [1:0] dir_reg;

    assign in_ready = scan_idle;
    assign in_fire  = in_valid && in_ready;
    assign take     = res.valid && (!out_valid_reg || out_ready);

    assign cmd.start = in_fire;
    assign cmd.cur   = ers_pkg::IDX_W'(current_floor);
    assign cmd.dir   = direction;

    ers_req_store u_store
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (in_fire),
        .op     (op),
        .floor  (floor),
        .button (button),
        .reqs   (reqs)
    );

    ers_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .reqs  (reqs),
        .take  (take),
        .idle  (scan_idle),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            target_reg <= 2'(res.target);
            dir_reg    <= res.dir;
        end
    end

    assign out_valid      = out_valid_reg;
    assign target_floor   = target_reg;
    assign next_direction = dir_reg;

endmodule

// ===== design/ers_req_store.sv =====
// ---------------------------------------------------------------------------
// ers_req_store
// Hall up, hall down and cabin request vectors, updated once per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ers_req_store
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [1:0]        op,
    input  logic [1:0]        floor,
    input  logic [1:0]        button,
    output ers_pkg::req_vec_t reqs
);

    ers_pkg::req_vec_t reqs_reg;
    ers_pkg::req_vec_t reqs_next;
    logic              floor_ok;
    logic [ers_pkg::FLOORS-1:0] floor_bit;

    assign floor_ok  = (int'(floor) < ers_pkg::FLOORS);
    assign floor_bit = floor_ok ? (ers_pkg::FLOORS'(1) << ers_pkg::IDX_W'(floor))
                                : '0;

    always_comb
    begin
        reqs_next = reqs_reg;
        unique case (op)
            ers_pkg::OP_ADD:
            begin
                case (button)
                    ers_pkg::BTN_UP:    reqs_next.up    = reqs_reg.up | floor_bit;
                    ers_pkg::BTN_DOWN:  reqs_next.down  = reqs_reg.down | floor_bit;
                    ers_pkg::BTN_CABIN: reqs_next.cabin = reqs_reg.cabin | floor_bit;
                    default:            reqs_next = reqs_reg;
                endcase
            end
            ers_pkg::OP_CLEAR_FLOOR:
            begin
                reqs_next.up    = reqs_reg.up & ~floor_bit;
                reqs_next.down  = reqs_reg.down & ~floor_bit;
                reqs_next.cabin = reqs_reg.cabin & ~floor_bit;
            end
            ers_pkg::OP_CLEAR_ALL:
            begin
                reqs_next = '0;
            end
            ers_pkg::OP_QUERY:
            begin
                reqs_next = reqs_reg;
            end
            default:
            begin
                reqs_next = reqs_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reqs_reg <= '0;
        end
        else if (wr_en)
        begin
            reqs_reg <= reqs_next;
        end
    end

    assign reqs = reqs_reg;

endmodule

// ===== design/ers_scan.sv =====
// ---------------------------------------------------------------------------
// ers_scan
// Target search: walks the floors one per cycle through a single bit test, first
// for preferred kinds (any kind, no fallback, if stopped), then any request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ers_scan
(
    input  logic               clk,
    input  logic               rst_n,
    input  ers_pkg::scan_cmd_t cmd,
    input  ers_pkg::req_vec_t  reqs,
    input  logic               take,
    output logic               idle,
    output ers_pkg::scan_res_t res
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FIRST  = 4'b0010,
        S_SECOND = 4'b0100,
        S_DONE   = 4'b1000
    } scan_state_t;

    typedef enum logic [1:0] {
        SEL_ANY,
        SEL_UP_CABIN,
        SEL_DOWN_CABIN
    } vec_sel_t;

    localparam logic [ers_pkg::IDX_W-1:0] TOP_IDX = ers_pkg::IDX_W'(ers_pkg::FLOORS - 1);

    scan_state_t                 state_reg, state_next;
    vec_sel_t                    sel_reg, sel_next;
    logic [ers_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [ers_pkg::IDX_W-1:0]   cur_reg, cur_next;
    logic                        step_up_reg, step_up_next;
    logic [ers_pkg::IDX_W-1:0]   target_reg, target_next;
    logic signed [1:0]           dir_reg, dir_next;

    logic [ers_pkg::FLOORS-1:0]  vec;
    logic                        hit;
    logic                        at_end;
    logic [ers_pkg::IDX_W-1:0]   cur_clamped;
    logic signed [1:0]           hit_dir;

    assign cur_clamped = (int'(cmd.cur) >= ers_pkg::FLOORS) ? TOP_IDX : cmd.cur;

    always_comb
    begin
        case (sel_reg)
            SEL_UP_CABIN:   vec = reqs.up | reqs.cabin;
            SEL_DOWN_CABIN: vec = reqs.down | reqs.cabin;
            default:        vec = reqs.up | reqs.down | reqs.cabin;
        endcase
    end

    assign hit    = vec[idx_reg];
    assign at_end = step_up_reg ? (idx_reg == TOP_IDX) : (idx_reg == '0);

    // sign of found floor minus current floor
    always_comb
    begin
        if (idx_reg > cur_reg)
            hit_dir = ers_pkg::DIR_UP;
        else if (idx_reg < cur_reg)
            hit_dir = ers_pkg::DIR_DOWN;
        else
            hit_dir = ers_pkg::DIR_STOP;
    end

    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        idx_next     = idx_reg;
        cur_next     = cur_reg;
        step_up_next = step_up_reg;
        target_next  = target_reg;
        dir_next     = dir_reg;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    cur_next = cur_clamped;
                    unique case (cmd.dir)
                        ers_pkg::DIR_STOP:
                        begin
                            state_next   = S_SECOND;
                            sel_next     = SEL_ANY;
                            idx_next     = '0;
                            step_up_next = 1'b1;
                        end
                        ers_pkg::DIR_UP:
                        begin
                            state_next   = S_FIRST;
                            sel_next     = SEL_UP_CABIN;
                            idx_next     = cur_clamped;
                            step_up_next = 1'b1;
                        end
                        ers_pkg::DIR_DOWN:
                        begin
                            state_next   = S_FIRST;
                            sel_next     = SEL_DOWN_CABIN;
                            idx_next     = cur_clamped;
                            step_up_next = 1'b0;
                        end
                        default:
                        begin
                            // undefined direction code: stay put
                            state_next  = S_DONE;
                            target_next = cur_clamped;
                            dir_next    = ers_pkg::DIR_STOP;
                        end
                    endcase
                end
            end
            S_FIRST, S_SECOND:
            begin
                if (hit)
                begin
                    state_next  = S_DONE;
                    target_next = idx_reg;
                    dir_next    = hit_dir;
                end
                else if (at_end && state_reg == S_FIRST)
                begin
                    // fallback sweeps any request from the far end, reversed
                    state_next   = S_SECOND;
                    sel_next     = SEL_ANY;
                    step_up_next = !step_up_reg;
                    idx_next     = step_up_reg ? TOP_IDX : '0;
                end
                else if (at_end)
                begin
                    state_next  = S_DONE;
                    target_next = cur_reg;
                    dir_next    = ers_pkg::DIR_STOP;
                end
                else
                begin
                    idx_next = step_up_reg ? idx_reg + 1'b1 : idx_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                if (take)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg     <= sel_next;
        idx_reg     <= idx_next;
        cur_reg     <= cur_next;
        step_up_reg <= step_up_next;
        target_reg  <= target_next;
        dir_reg     <= dir_next;
    end

    assign idle       = (state_reg == S_IDLE);
    assign res.valid  = (state_reg == S_DONE);
    assign res.target = target_reg;
    assign res.dir    = dir_reg;

endmodule

// ===== design/ers_checker.sv =====
// ---------------------------------------------------------------------------
// ers_checker
// Port-level checks for the scheduler, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ers_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [1:0]        op,
    input logic [1:0]        floor,
    input logic [1:0]        button,
    input logic [1:0]        current_floor,
    input logic signed [1:0] direction,
    input logic              out_valid,
    input logic              out_ready,
    input logic [1:0]        target_floor,
    input logic signed [1:0] next_direction
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(target_floor)
            && $stable(next_direction))
        else $error("output beat changed while stalled");

    // the scan leaves idle on an accepted beat, so no back-to-back input beats
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while scan busy");

    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (next_direction == ers_pkg::DIR_STOP
            || next_direction == ers_pkg::DIR_UP
            || next_direction == ers_pkg::DIR_DOWN))
        else $error("undefined direction on output");

    // moving up means the target is above some floor
    a_up_not_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && next_direction == ers_pkg::DIR_UP |-> target_floor != 2'd0)
        else $error("up toward the bottom floor");

    a_down_not_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && next_direction == ers_pkg::DIR_DOWN
            |-> int'(target_floor) != ers_pkg::FLOORS - 1)
        else $error("down toward the top floor");

endmodule

bind elevator_request_scheduler_unit ers_checker u_ers_checker (.*);
